// File: rtl/srb_pkg.sv
// srb_pkg: transaction types, field widths and command/status structs for the
// sequence reorder buffer. No dependencies; imported by every rtl module.

package srb_pkg;

   // fixed field widths of the frame and result transactions
   localparam int SEQ_BITS     = 8;
   localparam int PAYLOAD_BITS = 32;
   localparam int PEAK_W       = 5;

   // result status codes
   localparam logic STATUS_DELIVERED = 1'b0;
   localparam logic STATUS_REJECTED  = 1'b1;

   // input frame transaction
   typedef struct packed {
      logic [SEQ_BITS-1:0]     seq_number;
      logic [PAYLOAD_BITS-1:0] frame_payload;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [SEQ_BITS-1:0]     out_seq_number;
      logic [PAYLOAD_BITS-1:0] out_payload;
      logic                    status;
      logic                    last_of_run;
      logic [PEAK_W-1:0]       peak_held;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;       // latch the incoming frame
      logic emit_single;   // load a pass-through or reject result
      logic store;         // write the frame into its window slot
      logic read_head;     // fetch the head slot payload
      logic release_head;  // emit the head frame and advance the window
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic bypass;        // pass-through mode selected
      logic in_window;     // latched frame falls inside the window
      logic head_valid;    // head slot holds a frame
      logic out_free;      // output register can take a result this cycle
   } dp_status_type;

endpackage

// File: rtl/sequence_reorder_buffer_top.sv
// sequence_reorder_buffer_top: top level joining controller and datapath.
// Depends on srb_pkg, srb_ctrl and srb_datapath.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  srb_pkg::req_type
//  rsp      out        rsp_valid / rsp_stall  srb_pkg::rsp_type
//  csr      in         csr_wr_en              csr_wr_data (reorder_enable)
//
// A pass-through or rejected frame is captured, then evaluated and loaded
// into the output register. An in-window frame is captured, evaluated and
// stored; each released frame waits on the registered read of the payload
// memory. Synchronous reset clears slot valid bits, counters and the output
// valid bit; reorder mode is on after reset. A stalled result holds the
// sequencer in its emit step while the output register is full.

module sequence_reorder_buffer_top #(
   parameter int WINDOW = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srb_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);
   import srb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   srb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and result path
   srb_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // busy after every accepted transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accepted transaction");

   // results load only into a free output register
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_single || cmd.release_head) |-> status.out_free)
      else $error("result loaded over a pending transaction");

   // frames are stored only in reorder mode and inside the window
   a_store_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (!status.bypass && status.in_window))
      else $error("frame stored outside the window");

   // at most one datapath command per cycle
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.emit_single, cmd.store, cmd.read_head,
                cmd.release_head}))
      else $error("conflicting datapath commands");

endmodule

// File: rtl/srb_ctrl.sv
// srb_ctrl: sequencing state machine of the reorder buffer.
// Depends on srb_pkg for the command and status structs.

module srb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  srb_pkg::dp_status_type status,
   output srb_pkg::dp_cmd_type   cmd
);
   import srb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CHECK,
      ST_SEND
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.bypass || !status.in_window) begin
               if (status.out_free) begin
                  cmd.emit_single = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.store = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.head_valid) begin
               cmd.read_head = 1'b1;
               state_in      = ST_SEND;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.release_head = 1'b1;
               state_in         = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // new frames only while idle
   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: rtl/srb_datapath.sv
// srb_datapath: window slots, payload memory, counters and output register.
// Depends on srb_pkg for transaction types and command/status structs.

module srb_datapath #(
   parameter int WINDOW = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srb_pkg::req_type       req_data,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   input  srb_pkg::dp_cmd_type    cmd,
   output srb_pkg::dp_status_type status,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output srb_pkg::rsp_type       rsp_data
);
   import srb_pkg::*;

   localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int EFF_WIN = (WINDOW < (2 ** SEQ_BITS)) ? WINDOW : (2 ** SEQ_BITS);
   localparam logic [IDX_W:0]    WIN_EXT     = (IDX_W + 1)'(WINDOW);
   localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(WINDOW - 1);
   localparam logic [SEQ_BITS:0] EFF_WIN_EXT = (SEQ_BITS + 1)'(EFF_WIN);

   logic                    enable_ff;
   logic [SEQ_BITS-1:0]     in_seq_ff;
   logic [PAYLOAD_BITS-1:0] in_pay_ff;
   logic [WINDOW-1:0]       valid_ff;
   logic [PAYLOAD_BITS-1:0] slot_mem [WINDOW];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;
   logic [SEQ_BITS-1:0]     next_ff;
   logic [IDX_W-1:0]        head_ff;
   logic [CNT_W-1:0]        held_ff;
   logic [CNT_W-1:0]        peak_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_data_in;

   logic [SEQ_BITS-1:0]     offset;
   logic [IDX_W:0]          slot_sum;
   logic [IDX_W-1:0]        slot_idx;
   logic [IDX_W-1:0]        head_next;
   logic [CNT_W-1:0]        held_inc;
   logic [PEAK_W-1:0]       peak_out;
   logic                    out_free;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         enable_ff <= csr_wr_data;
      end
   end

   // latched frame
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_seq_ff <= req_data.seq_number;
         in_pay_ff <= req_data.frame_payload;
      end
   end

   // window offset and slot, sum stays below twice the window for in-window offsets
   assign offset   = in_seq_ff - next_ff;
   assign slot_sum = {1'b0, head_ff} + {1'b0, offset[IDX_W-1:0]};
   assign slot_idx = (slot_sum >= WIN_EXT) ? IDX_W'(slot_sum - WIN_EXT)
                                           : slot_sum[IDX_W-1:0];
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign held_inc  = held_ff + CNT_W'(1);

   // peak count as carried on the result
   if (CNT_W >= PEAK_W) begin : g_peak_trunc
      assign peak_out = peak_ff[PEAK_W-1:0];
   end else begin : g_peak_ext
      assign peak_out = {{(PEAK_W - CNT_W){1'b0}}, peak_ff};
   end

   // payload memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         slot_mem[slot_idx] <= in_pay_ff;
      end
      if (cmd.read_head) begin
         rd_data_ff <= slot_mem[head_ff];
      end
   end

   // slot valid bits, window head and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         next_ff  <= '0;
         head_ff  <= '0;
         held_ff  <= '0;
         peak_ff  <= '0;
      end else begin
         if (cmd.store && !valid_ff[slot_idx]) begin
            valid_ff[slot_idx] <= 1'b1;
            held_ff            <= held_inc;
            if (held_inc > peak_ff) begin
               peak_ff <= held_inc;
            end
         end
         if (cmd.release_head) begin
            valid_ff[head_ff] <= 1'b0;
            held_ff           <= held_ff - CNT_W'(1);
            next_ff           <= next_ff + 1'b1;
            head_ff           <= head_next;
         end
      end
   end

   // result selection
   always_comb begin
      rsp_data_in = rsp_data_ff;
      priority if (cmd.emit_single) begin
         rsp_data_in.out_seq_number = in_seq_ff;
         rsp_data_in.out_payload    = enable_ff ? '0 : in_pay_ff;
         rsp_data_in.status         = enable_ff ? STATUS_REJECTED : STATUS_DELIVERED;
         rsp_data_in.last_of_run    = 1'b1;
         rsp_data_in.peak_held      = peak_out;
      end else if (cmd.release_head) begin
         rsp_data_in.out_seq_number = next_ff;
         rsp_data_in.out_payload    = rd_data_ff;
         rsp_data_in.status         = STATUS_DELIVERED;
         rsp_data_in.last_of_run    = !valid_ff[head_next];
         rsp_data_in.peak_held      = peak_out;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_single || cmd.release_head) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status to the controller
   assign status.bypass     = !enable_ff;
   assign status.in_window  = ({1'b0, offset} < EFF_WIN_EXT);
   assign status.head_valid = valid_ff[head_ff];
   assign status.out_free   = out_free;

endmodule
